// ----- hdl/mst_pkg.sv -----
// Shared types and constants for the motor speed telemetry sanitiser.
`default_nettype none
package mst_pkg;
	localparam int unsigned TAPS = 5;
	localparam int unsigned FILL_W = $clog2(TAPS + 1);
	localparam logic [10:0] NEUTRAL_CMD = 11'd1048;
	localparam logic [10:0] REVERSE_MIN_CMD = 11'd48;
	localparam logic [9:0] DRIVEN_STEPS = 10'd50;
	localparam logic [15:0] MV_LOW = 16'd5000;
	localparam logic [15:0] MV_HIGH = 16'd10000;
	localparam logic [20:0] CEIL_DIV = 21'd1998000;

	localparam logic [2:0] REG_KV = 3'd0;
	localparam logic [2:0] REG_PP = 3'd1;
	localparam logic [2:0] REG_EMAX = 3'd2;
	localparam logic [2:0] REG_GMIN = 3'd3;
	localparam logic [2:0] REG_ESCUP = 3'd4;
	localparam logic [2:0] REG_ESCDN = 3'd5;
	localparam logic [2:0] REG_STALE = 3'd6;

	// Datapath commands issued by the controller.
	typedef struct packed {
		logic load;      // capture the incoming beat
		logic mul_a;     // steps * mv
		logic mul_b;     // * kv
		logic mul_c;     // * pole pairs * 3, lhs product
		logic med;       // register ring median
		logic commit;    // update state and result
	} mst_cmd_t;
endpackage
`default_nettype wire

// ----- hdl/mst_ctrl.sv -----
// Controller sequencing the datapath over one beat.
`default_nettype none
module mst_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_busy,
	output logic in_ready,
	output mst_pkg::mst_cmd_t cmd
);
	import mst_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MA   = 7'b0000010,
		S_MB   = 7'b0000100,
		S_MC   = 7'b0001000,
		S_MED  = 7'b0010000,
		S_WAIT = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_MA;
			S_MA:   state_d = S_MB;
			S_MB:   state_d = S_MC;
			S_MC:   state_d = S_MED;
			S_MED:  state_d = S_WAIT;
			S_WAIT: if (!out_busy) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = in_fire;
	assign cmd.mul_a = (state_q == S_MA);
	assign cmd.mul_b = (state_q == S_MB);
	assign cmd.mul_c = (state_q == S_MC);
	assign cmd.med = (state_q == S_MED);
	assign cmd.commit = (state_q == S_DONE);

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE) else $error("beat taken while busy");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MA |=> state_q == S_MB) else $error("sequence broken");
	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> $past(!out_busy)) else $error("commit while output full");
endmodule
`default_nettype wire

// ----- hdl/mst_dp.sv -----
// Datapath: ceiling product, ring, median, gates and held result.
`default_nettype none
module mst_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mst_pkg::mst_cmd_t cmd,
	input  wire logic telem_ok,
	input  wire logic [19:0] erpm_raw,
	input  wire logic [10:0] throttle_cmd,
	input  wire logic [15:0] battery_mv,
	input  wire logic [11:0] motor_kv,
	input  wire logic [4:0] pole_pairs,
	input  wire logic [15:0] speed_cap,
	input  wire logic [15:0] gate_floor,
	input  wire logic [5:0] escape_up,
	input  wire logic [5:0] escape_down,
	input  wire logic [5:0] stale_ticks,
	output logic res_valid,
	output logic [15:0] res_value
);
	import mst_pkg::*;

	logic ok_q;
	logic [19:0] raw_q;
	logic [10:0] cmd_q;
	logic [15:0] mv_q;
	logic [25:0] pa_q;   // steps * mv
	logic [37:0] pb_q;   // * kv
	logic [44:0] rhs_q;  // * pp * 3
	logic [40:0] lhs_q;  // raw * 1998000
	logic [15:0] med_q;
	logic [15:0] ring_q [TAPS];
	logic [FILL_W-1:0] fill_q;
	logic [5:0] rej_q, und_q;
	logic up_q;
	logic [9:0] steps_q;
	logic [15:0] pmv_q;
	logic hv_q;
	logic [15:0] hval_q;
	logic fill_fix_q;

	// Capture inputs of one beat.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok_q <= telem_ok;
			raw_q <= erpm_raw;
			cmd_q <= throttle_cmd;
			mv_q <= battery_mv;
		end
	end

	// Ceiling product, computed in the mul_a, mul_b and mul_c steps.
	always_ff @(posedge clk) begin
		if (cmd.mul_a) pa_q <= 26'(steps_q) * 26'(pmv_q);
		if (cmd.mul_b) pb_q <= 38'(pa_q) * 38'(motor_kv);
		if (cmd.mul_c) begin
			rhs_q <= 45'(pb_q) * 45'(7'(pole_pairs) * 7'd3);
			lhs_q <= 41'(raw_q) * 41'(CEIL_DIV);
		end
	end

	// Median of the newest fill_q samples by rank counting.
	logic [15:0] med_d;
	always_comb begin
		logic [FILL_W-1:0] lt, le;
		logic [FILL_W-1:0] k;
		med_d = '0;
		k = fill_q >> 1;
		for (int i = 0; i < TAPS; i++) begin
			lt = '0; le = '0;
			for (int j = 0; j < TAPS; j++) begin
				if (j < int'(fill_q)) begin
					if (ring_q[j] < ring_q[i] || (ring_q[j] == ring_q[i] && j < i))
						lt = lt + FILL_W'(1);
				end
			end
			le = lt;
			if (i < int'(fill_q) && le == k) med_d = ring_q[i];
		end
	end

	always_ff @(posedge clk) if (cmd.med) med_q <= med_d;

	// Decision logic.
	logic in_ceil, active, outlier, up, rej_hit;
	logic [5:0] run_n, lim;
	logic [9:0] steps_n;
	always_comb begin
		in_ceil = (raw_q <= 20'(speed_cap)) &&
			((pmv_q < MV_LOW || pmv_q > MV_HIGH) || (46'(lhs_q) <= 46'(rhs_q)));
		active = (fill_q != '0) && (med_q > gate_floor);
		outlier = active && ((21'(raw_q) << 1) < 21'(med_q) ||
			(24'(raw_q) * 24'd10) > (24'(med_q) * 24'd17));
		up = raw_q > 20'(med_q);
		lim = up ? escape_up : escape_down;
		if (rej_q == '0 || up != up_q) run_n = 6'd1;
		else run_n = rej_q + 6'd1;
		rej_hit = !(run_n < lim);
		if (cmd_q > NEUTRAL_CMD) steps_n = 10'(cmd_q - NEUTRAL_CMD);
		else if (cmd_q >= REVERSE_MIN_CMD && cmd_q < NEUTRAL_CMD)
			steps_n = 10'(cmd_q - REVERSE_MIN_CMD);
		else steps_n = '0;
	end

	// State update on commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) ring_q[i] <= '0;
			fill_q <= '0; rej_q <= '0; up_q <= 1'b0; und_q <= '0;
			steps_q <= '0; pmv_q <= '0; hv_q <= 1'b0; hval_q <= '0;
		end else if (cmd.commit) begin
			steps_q <= steps_n;
			pmv_q <= mv_q;
			if (steps_q < DRIVEN_STEPS) begin
				rej_q <= '0;
				if (und_q < stale_ticks) und_q <= und_q + 6'd1;
				else fill_q <= '0;
				hv_q <= 1'b0; hval_q <= '0;
			end else if (ok_q) begin
				und_q <= '0;
				if (!in_ceil) begin
					hv_q <= (fill_q != '0);
					hval_q <= (fill_q != '0) ? med_q : '0;
				end else if (outlier) begin
					hv_q <= 1'b1;
					up_q <= up;
					if (!rej_hit) begin
						rej_q <= run_n; hval_q <= med_q;
					end else begin
						for (int i = 0; i < TAPS; i++) ring_q[i] <= raw_q[15:0];
						fill_q <= FILL_W'(TAPS); rej_q <= '0; hval_q <= raw_q[15:0];
					end
				end else begin
					rej_q <= '0;
					for (int i = TAPS - 1; i > 0; i--) ring_q[i] <= ring_q[i-1];
					ring_q[0] <= raw_q[15:0];
					if (fill_q < FILL_W'(TAPS)) fill_q <= fill_q + FILL_W'(1);
					hv_q <= 1'b1; hval_q <= 16'hFFFF; // replaced below
				end
			end
		end else if (fill_fix_q) begin
			hval_q <= med_d;
		end
	end

	// Plain sample path: the median of the updated ring is taken in the cycle after the commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fill_fix_q <= 1'b0;
		else fill_fix_q <= cmd.commit && !(steps_q < DRIVEN_STEPS) && ok_q && in_ceil
			&& !outlier;
	end

	assign res_valid = hv_q;
	assign res_value = hval_q;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(TAPS)) else $error("fill count overrun");
	a_inval: assert property (@(posedge clk) disable iff (!arst_n)
		!hv_q |-> hval_q == '0) else $error("invalid result carries value");
	a_fix: assert property (@(posedge clk) disable iff (!arst_n)
		fill_fix_q |-> fill_q != '0) else $error("median of empty ring");
endmodule
`default_nettype wire

// ----- hdl/motor_speed_telemetry_sanitiser.sv -----
// Top level of the motor speed telemetry sanitiser.
// One input beat (one control tick) passes from acceptance to the result being offered through
// the ceiling multiplier chain, a registered median, the commit, the median refresh of the
// updated ring and the load of the output register. The next beat is taken from the cycle
// after the commit, so the block takes no new beat before it has committed the last one;
// while an earlier result still waits in the output register the controller holds before
// its commit, so a slow receiver stretches each beat by its stall.
`default_nettype none
module motor_speed_telemetry_sanitiser (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [47:0] s_axis_tdata, // telem_ok, erpm_raw, throttle_cmd, battery_mv
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // erpm_valid, erpm_value
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	import mst_pkg::*;

	logic [11:0] kv_q;
	logic [4:0] pp_q;
	logic [15:0] emax_q, gmin_q;
	logic [5:0] eup_q, edn_q, stale_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kv_q <= 12'd1100; pp_q <= 5'd7; emax_q <= 16'd65000; gmin_q <= 16'd3000;
			eup_q <= 6'd6; edn_q <= 6'd50; stale_q <= 6'd50;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KV:    kv_q <= cfg_wdata[11:0];
				REG_PP:    pp_q <= cfg_wdata[4:0];
				REG_EMAX:  emax_q <= cfg_wdata;
				REG_GMIN:  gmin_q <= cfg_wdata;
				REG_ESCUP: eup_q <= cfg_wdata[5:0];
				REG_ESCDN: edn_q <= cfg_wdata[5:0];
				REG_STALE: stale_q <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	mst_cmd_t cmd;
	logic in_fire, rv, pend_q, ov_q;
	logic [15:0] rval;
	logic [16:0] od_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	mst_ctrl u_ctrl (.clk, .arst_n, .in_fire, .out_busy(ov_q && !m_axis_tready),
		.in_ready(s_axis_tready), .cmd);

	mst_dp u_dp (.clk, .arst_n, .cmd,
		.telem_ok(s_axis_tdata[0]), .erpm_raw(s_axis_tdata[20:1]),
		.throttle_cmd(s_axis_tdata[31:21]), .battery_mv(s_axis_tdata[47:32]),
		.motor_kv(kv_q), .pole_pairs(pp_q), .speed_cap(emax_q), .gate_floor(gmin_q),
		.escape_up(eup_q), .escape_down(edn_q), .stale_ticks(stale_q),
		.res_valid(rv), .res_value(rval));

	// Output register, loaded through pend_q and pend2_q after commit once the median refresh is done.
	logic pend2_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0; pend2_q <= 1'b0; ov_q <= 1'b0; od_q <= '0;
		end else begin
			pend_q <= cmd.commit;
			pend2_q <= pend_q;
			if (pend2_q) begin
				ov_q <= 1'b1;
				od_q <= {rval, rv};
			end else if (m_axis_tready) ov_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {7'd0, od_q};
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for the motor speed telemetry sanitiser: random and directed ticks.
`default_nettype none
module tb_top;
	import mst_pkg::*;

	typedef struct packed {
		logic        ok;
		logic [19:0] erpm;
		logic [10:0] cmd;
		logic [15:0] mv;
	} tick_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] value;
	} speed_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	motor_speed_telemetry_sanitiser dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor copy of the configuration and state.
	logic [11:0] kv;
	logic [4:0] pp;
	logic [15:0] emax, gmin;
	logic [5:0] esc_up, esc_dn, stale;
	logic [15:0] ring [TAPS];
	int unsigned fill;
	logic [5:0] rej_run, idle_run;
	logic rej_up;
	logic [9:0] last_steps;
	logic [15:0] last_mv;
	speed_t held;

	tick_t pending_ticks[$];
	speed_t expected_speeds[$];
	int send_idle_pct = 0, recv_idle_pct = 0;
	int mismatches = 0, beats_in = 0, beats_out = 0;
	longint cycles = 0;

	function automatic logic [15:0] ring_mid();
		logic [15:0] t [TAPS];
		logic [15:0] k;
		int n, j;
		n = fill;
		if (n == 0) return 16'd0;
		for (int i = 0; i < n; i++) t[i] = ring[i];
		for (int i = 1; i < n; i++) begin
			k = t[i];
			j = i;
			while (j > 0 && t[j-1] > k) begin
				t[j] = t[j-1];
				j--;
			end
			t[j] = k;
		end
		return t[n/2];
	endfunction

	function automatic logic [9:0] steps_of(logic [10:0] c);
		if (c > NEUTRAL_CMD) return 10'(c - NEUTRAL_CMD);
		if (c >= REVERSE_MIN_CMD && c < NEUTRAL_CMD) return 10'(c - REVERSE_MIN_CMD);
		return 10'd0;
	endfunction

	function automatic bit under_ceiling(logic [19:0] v);
		logic [63:0] lhs, rhs;
		if (v > emax) return 1'b0;
		if (last_mv < MV_LOW || last_mv > MV_HIGH) return 1'b1;
		lhs = 64'(v) * 64'd1998000;
		rhs = 64'(last_steps) * last_mv * kv * pp * 64'd3;
		return lhs <= rhs;
	endfunction

	// Works out the sanitised speed for one tick and advances the predictor state.
	function automatic speed_t sanitise_tick(tick_t t);
		speed_t r;
		logic [15:0] m;
		logic [5:0] lim;
		bit up;
		r = held;
		if (last_steps < DRIVEN_STEPS) begin
			rej_run = '0;
			if (idle_run < stale) idle_run++;
			else fill = 0;
			r = '0;
		end else if (t.ok) begin
			idle_run = '0;
			m = ring_mid();
			if (!under_ceiling(t.erpm)) begin
				r.valid = fill > 0;
				r.value = r.valid ? m : 16'd0;
			end else if (fill > 0 && m > gmin && (64'(t.erpm) * 2 < m
					|| 64'(t.erpm) * 10 > 64'(m) * 17)) begin
				up = t.erpm > m;
				lim = up ? esc_up : esc_dn;
				if (rej_run == 0 || up != rej_up) begin
					rej_run = 6'd1;
					rej_up = up;
				end else rej_run = rej_run + 6'd1;
				r.valid = 1'b1;
				if (rej_run < lim) r.value = m;
				else begin
					for (int i = 0; i < TAPS; i++) ring[i] = t.erpm[15:0];
					fill = TAPS;
					rej_run = '0;
					r.value = t.erpm[15:0];
				end
			end else begin
				rej_run = '0;
				for (int i = TAPS - 1; i > 0; i--) ring[i] = ring[i-1];
				ring[0] = t.erpm[15:0];
				if (fill < TAPS) fill++;
				r.valid = 1'b1;
				r.value = ring_mid();
			end
		end
		held = r;
		last_steps = steps_of(t.cmd);
		last_mv = t.mv;
		return r;
	endfunction

	// Driver: presents pending ticks, idling at random.
	always @(posedge clk) begin
		tick_t at, nt;
		if (s_axis_tvalid && s_axis_tready) begin
			at.ok = s_axis_tdata[0];
			at.erpm = s_axis_tdata[20:1];
			at.cmd = s_axis_tdata[31:21];
			at.mv = s_axis_tdata[47:32];
			expected_speeds.push_back(sanitise_tick(at));
			beats_in++;
		end
		if ((!s_axis_tvalid || s_axis_tready) && arst_n) begin
			if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nt = pending_ticks.pop_front();
				s_axis_tdata <= {nt.mv, nt.cmd, nt.erpm, nt.ok};
				s_axis_tvalid <= 1'b1;
			end else s_axis_tvalid <= 1'b0;
		end
	end

	// Monitor: takes result beats and checks them against the oldest expectation.
	always @(posedge clk) begin
		speed_t got, want;
		cycles++;
		if (m_axis_tvalid && m_axis_tready) begin
			got.valid = m_axis_tdata[0];
			got.value = m_axis_tdata[16:1];
			beats_out++;
			if (expected_speeds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
			end else begin
				want = expected_speeds.pop_front();
				if (got.valid !== want.valid || got.value !== want.value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: expected valid %b value %0d, got valid %b value %0d",
							beats_out, want.valid, want.value, got.valid, got.value);
				end
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		if (cycles > 2000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KV: kv = val[11:0];
			REG_PP: pp = val[4:0];
			REG_EMAX: emax = val;
			REG_GMIN: gmin = val;
			REG_ESCUP: esc_up = val[5:0];
			REG_ESCDN: esc_dn = val[5:0];
			default: stale = val[5:0];
		endcase
	endtask

	task automatic drain();
		while (pending_ticks.size() > 0 || s_axis_tvalid || expected_speeds.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic tick_t driven_tick(logic [19:0] erpm);
		tick_t t;
		t.ok = $urandom_range(19) != 0;
		t.erpm = erpm;
		t.cmd = $urandom_range(9) == 0 ? 11'($urandom_range(60)) : 11'($urandom_range(2047));
		t.mv = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4900, 10100));
		return t;
	endfunction

	// Random ticks around a moving level, with jumps and occasional wide noise.
	task automatic queue_random(int n);
		int level;
		level = $urandom_range(20000);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: level = $urandom_range(65535);
				1: pending_ticks.push_back(driven_tick(20'($urandom)));
				2: pending_ticks.push_back(driven_tick(20'(level * 2 + $urandom_range(3000))));
				3: pending_ticks.push_back(driven_tick(20'(level / 3)));
				default: pending_ticks.push_back(
						driven_tick(20'(level + $urandom_range(level / 5 + 1))));
			endcase
		end
	endtask

	initial begin
		kv = 12'd1100; pp = 5'd7; emax = 16'd65000; gmin = 16'd3000;
		esc_up = 6'd6; esc_dn = 6'd50; stale = 6'd50;
		for (int i = 0; i < TAPS; i++) ring[i] = '0;
		fill = 0; rej_run = '0; idle_run = '0; rej_up = 1'b0;
		last_steps = '0; last_mv = '0; held = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(REG_STALE, 16'd3);
		write_reg(REG_ESCUP, 16'd2);
		write_reg(REG_ESCDN, 16'd3);

		// Directed: undriven start, stale drop, range, deviation and escapes, held output.
		pending_ticks.push_back('{1'b1, 20'hFFFFF, 11'd0, 16'd0});
		for (int i = 0; i < 5; i++) pending_ticks.push_back('{1'b1, 20'd9000, 11'd47, 16'd7000});
		pending_ticks.push_back('{1'b1, 20'd9000, 11'd2047, 16'd7400});
		for (int i = 0; i < 5; i++) pending_ticks.push_back('{1'b1, 20'd10000, 11'd1500, 16'd7400});
		pending_ticks.push_back('{1'b1, 20'd90000, 11'd1500, 16'd4999});
		pending_ticks.push_back('{1'b1, 20'd30000, 11'd1047, 16'd10001});
		pending_ticks.push_back('{1'b1, 20'd30000, 11'd1500, 16'd10000});
		pending_ticks.push_back('{1'b0, 20'd1, 11'd1500, 16'd5000});
		pending_ticks.push_back('{1'b1, 20'd1000, 11'd1500, 16'd5000});
		pending_ticks.push_back('{1'b1, 20'd1000, 11'd1048, 16'd5000});
		pending_ticks.push_back('{1'b1, 20'd1000, 11'd48, 16'hFFFF});
		pending_ticks.push_back('{1'b1, 20'd65000, 11'd98, 16'd0});
		pending_ticks.push_back('{1'b1, 20'd65535, 11'd1098, 16'd0});
		drain();

		// Randomised phases at several register settings, extremes included.
		for (int p = 0; p < 6; p++) begin
			send_idle_pct = p < 2 ? 28 : (p < 4 ? 71 : 0);
			recv_idle_pct = p < 2 ? 71 : (p < 4 ? 28 : 0);
			case (p)
				0: begin
					write_reg(REG_KV, 16'd4095); write_reg(REG_PP, 16'd31);
					write_reg(REG_EMAX, 16'd65535); write_reg(REG_GMIN, 16'd0);
				end
				1: begin
					write_reg(REG_KV, 16'd1); write_reg(REG_PP, 16'd1);
					write_reg(REG_ESCUP, 16'd63); write_reg(REG_ESCDN, 16'd1);
					write_reg(REG_STALE, 16'd63);
				end
				2: begin
					write_reg(REG_KV, 16'd1100); write_reg(REG_PP, 16'd7);
					write_reg(REG_EMAX, 16'd0); write_reg(REG_GMIN, 16'd65535);
					write_reg(REG_STALE, 16'd1);
				end
				3: begin
					write_reg(REG_EMAX, 16'd65000); write_reg(REG_GMIN, 16'd3000);
					write_reg(REG_ESCUP, 16'd0); write_reg(REG_ESCDN, 16'd0);
				end
				default: begin
					write_reg(REG_KV, 16'($urandom_range(1, 4095)));
					write_reg(REG_PP, 16'($urandom_range(1, 31)));
					write_reg(REG_ESCUP, 16'($urandom_range(1, 8)));
					write_reg(REG_ESCDN, 16'($urandom_range(1, 12)));
					write_reg(REG_STALE, 16'($urandom_range(1, 6)));
				end
			endcase
			queue_random(100);
			drain();
		end

		$display("covered %0d ticks and %0d results over six register settings", beats_in,
			beats_out);
		if (mismatches == 0) $display("tb_top passed");
		else $display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/mst_pkg.sv
hdl/mst_ctrl.sv
hdl/mst_dp.sv
hdl/motor_speed_telemetry_sanitiser.sv
test/tb_top.sv
